@@ hw/rtl/sawarq_pkg.sv @@
// ----------------------------------------------------------------------------
// sawarq_pkg
// types, codes and defaults shared by the stop-and-wait arq sender modules
// ----------------------------------------------------------------------------
package sawarq_pkg;

  // default sizes, handed down as top level parameter defaults
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_MAX_PAYLOAD = 64;

  // fixed field widths
  localparam int NUM_W  = 8;
  localparam int LEN_W  = 7;
  localparam int ATT_W  = 8;
  localparam int TICK_W = 16;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 16;

  // config register indexes
  localparam logic CFG_RETRY_LIMIT   = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  // config reset values
  localparam logic [ATT_W-1:0]  RETRY_LIMIT_RST   = 8'd3;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd10;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_NAK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_ABANDON = 2'd3
  } status_t;

  typedef struct packed {
    kind_t            kind;
    logic [NUM_W-1:0] pkg_number;
    logic [NUM_W-1:0] seg_number;
    logic [LEN_W-1:0] seg_length;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic             send_valid;
    logic [NUM_W-1:0] send_pkg;
    logic [NUM_W-1:0] send_seg;
    logic [LEN_W-1:0] send_len;
    logic [ATT_W-1:0] send_attempt;
    logic [CNT_W-1:0] dropped_count;
    logic [CNT_W-1:0] queue_level;
  } out_item_t;

  // one queued segment descriptor
  typedef struct packed {
    logic [NUM_W-1:0] pkg;
    logic [NUM_W-1:0] seg;
    logic [LEN_W-1:0] len;
  } desc_t;

  // controller to datapath
  typedef struct packed {
    logic take;    // latch the input item
    logic exec;    // apply the item's own action
    logic pop;     // drop the head during a package drop
    logic finish;  // start a send if idle, load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop_go;    // the item drops a package and the queue is not empty
    logic drop_more;  // the head belongs to the dropped package
    logic out_free;   // result register can be loaded
  } sts_t;

endpackage

@@ hw/rtl/sawarq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sawarq_ctrl
// sequencer: steps one item through execute, drop walk and send decision
// ----------------------------------------------------------------------------
module sawarq_ctrl
  import sawarq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DROP_RD,
    ST_DROP_CHK,
    ST_SEND_RD,
    ST_FINAL
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    cmd.take   = (state_r == ST_IDLE) && in_valid;
    cmd.exec   = (state_r == ST_EXEC);
    cmd.pop    = (state_r == ST_DROP_CHK) && sts.drop_more;
    cmd.finish = (state_r == ST_FINAL) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:     state_nxt = sts.drop_go ? ST_DROP_RD : ST_SEND_RD;
      ST_DROP_RD:  state_nxt = ST_DROP_CHK;
      // head unchanged when the walk stops, so its read data is current
      ST_DROP_CHK: state_nxt = sts.drop_more ? ST_DROP_RD : ST_FINAL;
      ST_SEND_RD:  state_nxt = ST_FINAL;
      ST_FINAL:    if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
    in_stall_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

@@ hw/rtl/sawarq_dp.sv @@
// ----------------------------------------------------------------------------
// sawarq_dp
// datapath: descriptor queue, sender state, config registers, result register
// ----------------------------------------------------------------------------
module sawarq_dp
  import sawarq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  desc_t mem [QUEUE_DEPTH];
  desc_t rd_r;

  in_item_t item_r;

  logic [PtrW-1:0]   head_ptr_r, head_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic [NUM_W-1:0]  awaited_pkg_r, awaited_pkg_nxt;
  logic [NUM_W-1:0]  awaited_seg_r, awaited_seg_nxt;
  logic [ATT_W-1:0]  attempt_r, attempt_nxt;
  logic [TICK_W-1:0] countdown_r, countdown_nxt;
  status_t           status_r, status_nxt;
  logic [CntW-1:0]   dropped_r, dropped_nxt;
  logic              resend_r, resend_nxt;
  logic [ATT_W-1:0]  retry_limit_r;
  logic [TICK_W-1:0] timeout_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [PtrW-1:0]   head_inc;
  logic [CntW:0]     tail_sum;
  logic [PtrW-1:0]   tail_ptr;
  logic              full;
  logic              match;
  logic              expired_out;
  logic              drop_req;
  logic              wr_en;
  desc_t             wr_desc;
  logic              send_new;

  always_comb begin
    head_inc = (head_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_r + 1'b1;
    tail_sum = (CntW + 1)'(head_ptr_r) + (CntW + 1)'(count_r);
    if (tail_sum >= (CntW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CntW + 1)'(QUEUE_DEPTH);
    end
    tail_ptr = PtrW'(tail_sum);
    full     = (count_r == CntW'(QUEUE_DEPTH));
    match    = awaiting_r && (item_r.pkg_number == awaited_pkg_r)
               && (item_r.seg_number == awaited_seg_r);
    // countdown ran out and attempts are used up
    expired_out = awaiting_r && (countdown_r == '0) && (attempt_r >= retry_limit_r);
    drop_req = ((item_r.kind == KIND_NAK) && match)
               || ((item_r.kind == KIND_TICK) && expired_out);
    wr_en    = cmd.exec && (item_r.kind == KIND_ENQ) && !full;
    wr_desc.pkg = item_r.pkg_number;
    wr_desc.seg = item_r.seg_number;
    // clamp oversized payload lengths
    if ({1'b0, item_r.seg_length} > (LEN_W + 1)'(MAX_PAYLOAD)) begin
      wr_desc.len = LEN_W'(MAX_PAYLOAD);
    end else begin
      wr_desc.len = item_r.seg_length;
    end
    send_new = !awaiting_r && (count_r != '0);
  end

  assign sts.drop_go   = drop_req && (count_r != '0);
  assign sts.drop_more = (count_r != '0) && (rd_r.pkg == awaited_pkg_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    head_ptr_nxt    = head_ptr_r;
    count_nxt       = count_r;
    awaiting_nxt    = awaiting_r;
    awaited_pkg_nxt = awaited_pkg_r;
    awaited_seg_nxt = awaited_seg_r;
    attempt_nxt     = attempt_r;
    countdown_nxt   = countdown_r;
    status_nxt      = status_r;
    dropped_nxt     = dropped_r;
    resend_nxt      = resend_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && out_stall;

    if (cmd.take) begin
      status_nxt  = STAT_OK;
      dropped_nxt = '0;
      resend_nxt  = 1'b0;
    end

    if (cmd.exec) begin
      unique case (item_r.kind)
        KIND_ENQ: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        KIND_TICK: begin
          if (awaiting_r) begin
            if (countdown_r != '0) begin
              countdown_nxt = countdown_r - 1'b1;
            end else if (attempt_r >= retry_limit_r) begin
              status_nxt = STAT_ABANDON;
            end else begin
              attempt_nxt   = attempt_r + 1'b1;
              countdown_nxt = timeout_r;
              resend_nxt    = 1'b1;
            end
          end
        end
        KIND_ACK, KIND_NAK: begin
          if (!match) begin
            status_nxt = STAT_IGNORED;
          end else begin
            awaiting_nxt = 1'b0;
            if ((item_r.kind == KIND_ACK) && (count_r != '0)) begin
              head_ptr_nxt = head_inc;
              count_nxt    = count_r - 1'b1;
              dropped_nxt  = CntW'(1);
            end
          end
        end
        default: ;
      endcase
      // package drop: first pop here, the rest walk over later cycles
      if (drop_req) begin
        awaiting_nxt = 1'b0;
        if (count_r != '0) begin
          head_ptr_nxt = head_inc;
          count_nxt    = count_r - 1'b1;
          dropped_nxt  = CntW'(1);
        end
      end
    end

    if (cmd.pop) begin
      head_ptr_nxt = head_inc;
      count_nxt    = count_r - 1'b1;
      dropped_nxt  = dropped_r + 1'b1;
    end

    if (cmd.finish) begin
      if (send_new) begin
        awaiting_nxt    = 1'b1;
        awaited_pkg_nxt = rd_r.pkg;
        awaited_seg_nxt = rd_r.seg;
        attempt_nxt     = ATT_W'(1);
        countdown_nxt   = timeout_r;
      end
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = status_r;
      out_data_nxt.send_valid    = send_new || resend_r;
      out_data_nxt.send_pkg      = '0;
      out_data_nxt.send_seg      = '0;
      out_data_nxt.send_len      = '0;
      out_data_nxt.send_attempt  = '0;
      if (send_new || resend_r) begin
        out_data_nxt.send_pkg     = rd_r.pkg;
        out_data_nxt.send_seg     = rd_r.seg;
        out_data_nxt.send_len     = rd_r.len;
        out_data_nxt.send_attempt = send_new ? ATT_W'(1) : attempt_r;
      end
      out_data_nxt.dropped_count = CNT_W'(dropped_r);
      out_data_nxt.queue_level   = CNT_W'(count_r);
    end
  end

  // descriptor memory, one write port at the tail, one registered read at the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_ptr] <= wr_desc;
    end
    rd_r <= mem[head_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
    status_r   <= status_nxt;
    dropped_r  <= dropped_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ptr_r    <= '0;
      count_r       <= '0;
      awaiting_r    <= 1'b0;
      awaited_pkg_r <= '0;
      awaited_seg_r <= '0;
      attempt_r     <= '0;
      countdown_r   <= '0;
      resend_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      retry_limit_r <= RETRY_LIMIT_RST;
      timeout_r     <= TIMEOUT_TICKS_RST;
    end else begin
      head_ptr_r    <= head_ptr_nxt;
      count_r       <= count_nxt;
      awaiting_r    <= awaiting_nxt;
      awaited_pkg_r <= awaited_pkg_nxt;
      awaited_seg_r <= awaited_seg_nxt;
      attempt_r     <= attempt_nxt;
      countdown_r   <= countdown_nxt;
      resend_r      <= resend_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RETRY_LIMIT:   retry_limit_r <= ATT_W'(cfg_wdata);
          CFG_TIMEOUT_TICKS: timeout_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/stop_and_wait_arq_sender.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender
// stop-and-wait arq sender over a circular queue of segment descriptors
// ----------------------------------------------------------------------------
// each input item is an enqueue, a time tick, an ack or a nak, and gives
// exactly one result item. one segment is in flight at a time: the queue
// head. a matching ack pops it; a matching nak, or a timeout once the retry
// limit is used up, drops the head and every directly following segment of
// the same package. an idle sender with a non-empty queue sends the head at
// once as attempt 1. an item passes the execute, head read and final
// states, the last registering its result; a drop walks read and check
// states until the head leaves the package; each new head is read back via
// the single registered read port of the descriptor memory to be compared.
// a result still waiting at the output does not block acceptance of the
// next item, only the loading of that item's result. config registers are
// written through cfg_we/cfg_index/cfg_wdata while the block is idle.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender
  import sawarq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,  // descriptor queue entries
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD   // longer segments are clamped
) (
  input  logic             clk,
  input  logic             rst_n,
  // input item channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // result item channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  // config write port
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer
  sawarq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // queue, sender state and result register
  sawarq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ bench/stop_and_wait_arq_sender_test.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_test
// self-checking regression for the stop-and-wait arq sender
// ----------------------------------------------------------------------------
// a bit-accurate model of the sender queue, retry counter and timeout
// countdown predicts one result item per accepted input item. directed
// tests cover stray acks and naks, clamped lengths, a full queue, the nak
// drop walk and abandonment at the retry limit. random phases then run
// well-formed ack/nak traffic mixed with noise, under several register
// settings and with idle gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender_test;
  import sawarq_pkg::*;

  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int MAX_PAYLOAD = DEF_MAX_PAYLOAD;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;  // longest item plus margin

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // pressure knobs, percent per cycle
  int gap_pct = 0;
  int stall_pct = 0;

  int fail_count = 0;

  // predicted result items, oldest first
  out_item_t sender_reports_due[$];

  // model copy of the sender
  desc_t ring [QUEUE_DEPTH];
  int    ring_head = 0;
  int    ring_fill = 0;
  logic  in_flight = 1'b0;
  logic [NUM_W-1:0] flight_pkg = '0;
  logic [NUM_W-1:0] flight_seg = '0;
  int    tries = 0;
  int    ticks_left = 0;
  int    cfg_retries = RETRY_LIMIT_RST;
  int    cfg_timeout = TIMEOUT_TICKS_RST;

  // segment stream used by random enqueues
  logic [NUM_W-1:0] stream_pkg = '0;
  logic [NUM_W-1:0] stream_seg = '0;

  stop_and_wait_arq_sender i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void pop_ring();
    if (ring_fill > 0) begin
      ring_head = (ring_head + 1) % QUEUE_DEPTH;
      ring_fill--;
    end
  endfunction

  // head and all directly following segments of the in-flight package
  function automatic int drop_flight_package();
    int n;
    n = 0;
    if (ring_fill > 0) begin
      pop_ring();
      n++;
      while (ring_fill > 0 && ring[ring_head].pkg == flight_pkg) begin
        pop_ring();
        n++;
      end
    end
    in_flight = 1'b0;
    return n;
  endfunction

  function automatic out_item_t next_sender_report(input in_item_t it);
    out_item_t        r;
    logic [LEN_W-1:0] len;
    logic             send;
    int               drops;
    int               slot;
    r = '0;
    r.status = STAT_OK;
    send = 1'b0;
    drops = 0;
    case (it.kind)
      KIND_ENQ: begin
        if (ring_fill >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          slot = (ring_head + ring_fill) % QUEUE_DEPTH;
          // oversized segments are clamped to the payload limit
          len = (it.seg_length > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : it.seg_length;
          ring[slot].pkg = it.pkg_number;
          ring[slot].seg = it.seg_number;
          ring[slot].len = len;
          ring_fill++;
        end
      end
      KIND_TICK: begin
        // a tick while idle does nothing
        if (in_flight) begin
          if (ticks_left > 0) begin
            ticks_left--;
          end else if (tries >= cfg_retries) begin
            drops = drop_flight_package();
            r.status = STAT_ABANDON;
          end else begin
            tries++;
            ticks_left = cfg_timeout;
            send = 1'b1;
          end
        end
      end
      default: begin
        if (!in_flight || it.pkg_number != flight_pkg || it.seg_number != flight_seg) begin
          r.status = STAT_IGNORED;
        end else if (it.kind == KIND_ACK) begin
          if (ring_fill > 0) begin
            pop_ring();
            drops = 1;
          end
          in_flight = 1'b0;
        end else begin
          drops = drop_flight_package();
        end
      end
    endcase
    // idle sender with queued work sends the head as attempt 1
    if (!in_flight && ring_fill > 0) begin
      in_flight = 1'b1;
      flight_pkg = ring[ring_head].pkg;
      flight_seg = ring[ring_head].seg;
      tries = 1;
      ticks_left = cfg_timeout;
      send = 1'b1;
    end
    r.send_valid = send;
    if (send) begin
      r.send_pkg = ring[ring_head].pkg;
      r.send_seg = ring[ring_head].seg;
      r.send_len = ring[ring_head].len;
      r.send_attempt = ATT_W'(tries);
    end
    r.dropped_count = CNT_W'(drops);
    r.queue_level = CNT_W'(ring_fill);
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic in_item_t make_item(input kind_t k, input logic [NUM_W-1:0] p,
                                         input logic [NUM_W-1:0] s,
                                         input logic [LEN_W-1:0] l);
    in_item_t it;
    it.kind = k;
    it.pkg_number = p;
    it.seg_number = s;
    it.seg_length = l;
    return it;
  endfunction

  // mostly well-formed traffic: segment streams per package, acks and naks
  // aimed at the in-flight segment, with some noise and near misses
  function automatic in_item_t random_item(input int enq_pct, input int tick_pct);
    in_item_t it;
    int       roll;
    roll = $urandom_range(99);
    it.pkg_number = NUM_W'($urandom_range(255));
    it.seg_number = NUM_W'($urandom_range(255));
    if ($urandom_range(4) == 0) it.seg_length = LEN_W'($urandom_range(127));
    else it.seg_length = LEN_W'($urandom_range(MAX_PAYLOAD));
    if (roll < enq_pct) begin
      it.kind = KIND_ENQ;
      if ($urandom_range(9) < 9) begin
        if ($urandom_range(9) < 3) begin
          stream_pkg = NUM_W'($urandom_range(255));
          stream_seg = '0;
        end else begin
          stream_seg = stream_seg + 1'b1;
        end
        it.pkg_number = stream_pkg;
        it.seg_number = stream_seg;
      end
    end else if (roll < enq_pct + tick_pct) begin
      it.kind = KIND_TICK;
    end else begin
      it.kind = ($urandom_range(9) < 7) ? KIND_ACK : KIND_NAK;
      if (in_flight && $urandom_range(9) < 8) begin
        it.pkg_number = flight_pkg;
        it.seg_number = flight_seg;
      end else if ($urandom_range(1) == 1) begin
        // near miss on the segment number
        it.pkg_number = flight_pkg;
        it.seg_number = flight_seg + 1'b1;
      end
    end
    return it;
  endfunction

  // valid stays high after acceptance so that back-to-back items need no
  // second assignment in the same step; gaps lower it first
  task automatic send_item(input in_item_t it);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sender_reports_due.push_back(next_sender_report(it));
  endtask

  // let every expected result drain, then idle for the settle margin
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sender_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes the retry limit and then the timeout register, block idle
  task automatic apply_settings(input logic [CFG_W-1:0] retries,
                                input logic [CFG_W-1:0] timeout);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_wdata <= retries;
    @(posedge clk);
    cfg_retries = int'(retries[ATT_W-1:0]);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_timeout = int'(timeout[TICK_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pressure(input int gap, input int stall);
    gap_pct = gap;
    stall_pct = stall;
  endtask

  // --------------------------------------------------------------- checker

  always @(posedge clk) begin
    stall_pct_apply: out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sender_reports_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result item %h", out_data);
      end else begin
        want = sender_reports_due.pop_front();
        if (out_data.status !== want.status ||
            out_data.send_valid !== want.send_valid ||
            out_data.send_pkg !== want.send_pkg ||
            out_data.send_seg !== want.send_seg ||
            out_data.send_len !== want.send_len ||
            out_data.send_attempt !== want.send_attempt ||
            out_data.dropped_count !== want.dropped_count ||
            out_data.queue_level !== want.queue_level) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch (exp/got): status %0d/%0d send %0b/%0b pkg %h/%h seg %h/%h",
                     want.status, out_data.status, want.send_valid, out_data.send_valid,
                     want.send_pkg, out_data.send_pkg, want.send_seg, out_data.send_seg,
                     " len %0d/%0d att %0d/%0d drop %0d/%0d level %0d/%0d",
                     want.send_len, out_data.send_len, want.send_attempt,
                     out_data.send_attempt, want.dropped_count, out_data.dropped_count,
                     want.queue_level, out_data.queue_level);
        end
      end
    end
  end

  // ----------------------------------------------------------------- tests

  // tick, ack and nak with nothing in flight
  task automatic test_idle_strays();
    send_item(make_item(KIND_TICK, 8'h00, 8'h00, 7'd0));
    send_item(make_item(KIND_ACK, 8'h00, 8'h00, 7'd0));
    send_item(make_item(KIND_NAK, 8'hFF, 8'hFF, 7'd127));
    wait_idle();
  endtask

  // max fields with clamped length, mismatching acks and naks, then a match
  task automatic test_ack_match();
    send_item(make_item(KIND_ENQ, 8'hFF, 8'hFF, 7'd127));
    send_item(make_item(KIND_ACK, 8'hFF, 8'hFE, 7'd0));
    send_item(make_item(KIND_NAK, 8'h7F, 8'hFF, 7'd0));
    send_item(make_item(KIND_ACK, 8'hFF, 8'hFF, 7'd0));
    wait_idle();
  endtask

  // fill the queue, overflow it, then nak the first package away
  task automatic test_full_nak_walk();
    logic [LEN_W-1:0] len;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == 0) len = 7'd0;
      else if (i == 1) len = LEN_W'(MAX_PAYLOAD);
      else if (i == 2) len = LEN_W'(MAX_PAYLOAD + 1);
      else len = LEN_W'(i * 7);
      send_item(make_item(KIND_ENQ, (i < 5) ? 8'h5A : 8'hA5, NUM_W'(i), len));
    end
    send_item(make_item(KIND_ENQ, 8'h11, 8'h22, 7'd33));
    // drop walk stops at the first segment of the other package
    send_item(make_item(KIND_NAK, 8'h5A, 8'h00, 7'd0));
    wait_idle();
  endtask

  // retry limit zero: the first timeout abandons, next package sent at once
  task automatic test_abandon();
    apply_settings(16'd0, 16'd0);
    send_item(make_item(KIND_TICK, 8'h00, 8'h00, 7'd0));
    send_item(make_item(KIND_ENQ, 8'h01, 8'h00, 7'd10));
    send_item(make_item(KIND_ENQ, 8'h02, 8'h00, 7'd20));
    send_item(make_item(KIND_TICK, 8'h00, 8'h00, 7'd0));
    send_item(make_item(KIND_TICK, 8'h00, 8'h00, 7'd0));
    wait_idle();
  endtask

  task automatic test_random_phase(input int count, input int enq_pct, input int tick_pct);
    repeat (count) send_item(random_item(enq_pct, tick_pct));
    wait_idle();
  endtask

  // ------------------------------------------------------------------ main

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset settings until test_abandon lowers them, no idling
    test_idle_strays();
    test_ack_match();
    test_full_nak_walk();
    test_abandon();

    // reset values again, free flow
    apply_settings(16'd3, 16'd10);
    test_random_phase(100, 35, 35);

    // lowest settings, sender mostly idle
    apply_settings(16'd0, 16'd0);
    set_pressure(87, 0);
    test_random_phase(100, 40, 30);

    // many retries and rare acks so attempt numbers climb high
    apply_settings(16'hFFFF, 16'd0);
    set_pressure(0, 87);
    test_random_phase(260, 3, 95);

    // longest timeout, enqueue heavy so the queue overflows
    apply_settings(16'd1, 16'hFFFF);
    set_pressure(33, 33);
    test_random_phase(100, 60, 10);

    apply_settings(16'd2, 16'd2);
    set_pressure(0, 0);
    test_random_phase(100, 35, 40);

    // random small settings, upper retry bits set as noise
    apply_settings({8'($urandom_range(255)), 8'($urandom_range(6))},
                   16'($urandom_range(4)));
    set_pressure(33, 33);
    test_random_phase(100, 35, 40);

    if (sender_reports_due.size() != 0) begin
      fail_count++;
      $display("%0d expected result items never arrived", sender_reports_due.size());
    end
    if (fail_count == 0) begin
      $display("stop_and_wait_arq_sender regression: pass");
    end else begin
      $display("stop_and_wait_arq_sender regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("stop_and_wait_arq_sender regression: fail");
    $finish;
  end

endmodule
